>>> rtl/glc_pkg.sv
// Package for the glyph LRU cache: field widths, entry and stamp types,
// request codes and the compare-unit result struct. No dependencies.
package glc_pkg;

  localparam int KEY_W   = 21;
  localparam int GLYPH_W = 16;
  localparam int FACE_W  = 4;
  localparam int STAMP_W = 48;
  localparam int ENTRY_W = KEY_W + GLYPH_W + FACE_W;

  typedef logic [KEY_W-1:0]   key_t;
  typedef logic [GLYPH_W-1:0] glyph_t;
  typedef logic [FACE_W-1:0]  face_t;
  typedef logic [STAMP_W-1:0] stamp_t;

  // One stored entry, key in the lowest bits.
  typedef struct packed {
    face_t  face;
    glyph_t glyph;
    key_t   key;
  } entry_t;

  typedef enum logic {
    REQ_LOOKUP = 1'b0,
    REQ_CLEAR  = 1'b1
  } req_type_t;

  // Result of the shared compare unit for the entry currently read.
  typedef struct packed {
    logic key_eq;
    logic stamp_lt;
  } cmp_res_t;

endpackage

>>> rtl/glc_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; used for the entry store and the stamp store.
module glc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/glc_cmp.sv
// Shared compare unit of the glyph LRU cache: key equality against the
// request and stamp order against the oldest stamp seen so far. Uses glc_pkg.
module glc_cmp (
  input  glc_pkg::key_t     ent_key,
  input  glc_pkg::key_t     req_key,
  input  glc_pkg::stamp_t   ent_stamp,
  input  glc_pkg::stamp_t   min_stamp,
  output glc_pkg::cmp_res_t res
);

  import glc_pkg::*;

  always_comb begin
    res.key_eq   = (ent_key == req_key);
    res.stamp_lt = (ent_stamp < min_stamp);
  end

endmodule

>>> rtl/glyph_lru_cache.sv
// Glyph LRU cache: a lookup scans the filled entries one per cycle through a
// shared compare unit and stops at a hit; a miss goes on to a decision state.
// A clear goes straight to the result state. A new request is taken only in
// the idle state, after the last result has been loaded into the output
// register, so requests do not overlap; the stores have a single read port.
// Synchronous active-low reset empties the cache; the stores are not cleared.
module glyph_lru_cache #(
  parameter int CACHE_ENTRIES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // char_code[20:0], glyph_id[36:21], face_sel[40:37],
                                  // load_ok[41], zero[47:42]
  input  logic        in_tuser,   // req_type[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // out_glyph[15:0], out_face[19:16],
                                  // evicted_char[40:20], zero[47:41]
  output logic [2:0]  out_tuser   // found[0], hit[1], evicted[2]
);

  import glc_pkg::*;

  localparam int IW = $clog2(CACHE_ENTRIES);
  localparam int FW = $clog2(CACHE_ENTRIES + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_RESP
  } state_t;

  state_t          state_r;
  logic [FW-1:0]   fill_r;
  stamp_t          clock_r;
  stamp_t          now_r;
  key_t            req_key_r;
  glyph_t          req_glyph_r;
  face_t           req_face_r;
  logic            req_load_r;
  logic [IW-1:0]   chk_idx_r;
  logic [IW-1:0]   min_idx_r;
  stamp_t          min_stamp_r;
  key_t            min_key_r;
  logic            res_found_r;
  logic            res_hit_r;
  glyph_t          res_glyph_r;
  face_t           res_face_r;
  logic            res_ev_r;
  key_t            res_ev_key_r;
  logic            out_tvalid_r;
  logic [47:0]     out_tdata_r;
  logic [2:0]      out_tuser_r;

  logic            in_xfer;
  logic            out_load;
  logic            full;
  logic            last_chk;
  logic            take_min;
  logic [IW-1:0]   rd_addr;
  logic            data_we;
  logic            stamp_we;
  logic [IW-1:0]   data_waddr;
  logic [IW-1:0]   stamp_waddr;
  entry_t          wr_entry;
  logic [ENTRY_W-1:0] rd_entry_bits;
  entry_t          rd_entry;
  stamp_t          rd_stamp;
  cmp_res_t        cmp;

  assign in_tready  = (state_r == S_IDLE);
  assign in_xfer    = in_tvalid && in_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // The result register may still hold the previous transfer.
  assign out_load = (state_r == S_RESP) && (!out_tvalid_r || out_tready);

  assign full     = (fill_r == FW'(CACHE_ENTRIES));
  assign last_chk = ((FW'(chk_idx_r) + FW'(1)) == fill_r);
  assign rd_entry = entry_t'(rd_entry_bits);
  // The first entry read always seeds the oldest-stamp search.
  assign take_min = (chk_idx_r == '0) || cmp.stamp_lt;

  always_comb begin
    rd_addr = '0;
    if (state_r == S_SCAN) begin
      rd_addr = chk_idx_r + IW'(1);
    end
  end

  always_comb begin
    data_we        = (state_r == S_DECIDE) && req_load_r;
    data_waddr     = full ? min_idx_r : fill_r[IW-1:0];
    stamp_we       = data_we || ((state_r == S_SCAN) && cmp.key_eq);
    stamp_waddr    = (state_r == S_SCAN) ? chk_idx_r : data_waddr;
    wr_entry.key   = req_key_r;
    wr_entry.glyph = req_glyph_r;
    wr_entry.face  = req_face_r;
  end

  glc_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(CACHE_ENTRIES)
  ) u_entry_ram (
    .clk   (clk),
    .we    (data_we),
    .waddr (data_waddr),
    .wdata (ENTRY_W'(wr_entry)),
    .raddr (rd_addr),
    .rdata (rd_entry_bits)
  );

  glc_ram #(
    .WIDTH(STAMP_W),
    .DEPTH(CACHE_ENTRIES)
  ) u_stamp_ram (
    .clk   (clk),
    .we    (stamp_we),
    .waddr (stamp_waddr),
    .wdata (now_r),
    .raddr (rd_addr),
    .rdata (rd_stamp)
  );

  glc_cmp u_cmp (
    .ent_key   (rd_entry.key),
    .req_key   (req_key_r),
    .ent_stamp (rd_stamp),
    .min_stamp (min_stamp_r),
    .res       (cmp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      fill_r       <= '0;
      clock_r      <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            req_key_r   <= in_tdata[20:0];
            req_glyph_r <= in_tdata[36:21];
            req_face_r  <= in_tdata[40:37];
            req_load_r  <= in_tdata[41];
            chk_idx_r   <= '0;
            if (req_type_t'(in_tuser) == REQ_CLEAR) begin
              fill_r       <= '0;
              res_found_r  <= 1'b0;
              res_hit_r    <= 1'b0;
              res_glyph_r  <= '0;
              res_face_r   <= '0;
              res_ev_r     <= 1'b0;
              res_ev_key_r <= '0;
              state_r      <= S_RESP;
            end else begin
              now_r   <= clock_r;
              clock_r <= clock_r + STAMP_W'(1);
              state_r <= (fill_r == '0) ? S_DECIDE : S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (cmp.key_eq) begin
            res_found_r  <= 1'b1;
            res_hit_r    <= 1'b1;
            res_glyph_r  <= rd_entry.glyph;
            res_face_r   <= rd_entry.face;
            res_ev_r     <= 1'b0;
            res_ev_key_r <= '0;
            state_r      <= S_RESP;
          end else begin
            if (take_min) begin
              min_idx_r   <= chk_idx_r;
              min_stamp_r <= rd_stamp;
              min_key_r   <= rd_entry.key;
            end
            if (last_chk) begin
              state_r <= S_DECIDE;
            end else begin
              chk_idx_r <= chk_idx_r + IW'(1);
            end
          end
        end
        S_DECIDE: begin
          res_hit_r <= 1'b0;
          if (!req_load_r) begin
            res_found_r  <= 1'b0;
            res_glyph_r  <= '0;
            res_face_r   <= '0;
            res_ev_r     <= 1'b0;
            res_ev_key_r <= '0;
          end else begin
            res_found_r <= 1'b1;
            res_glyph_r <= req_glyph_r;
            res_face_r  <= req_face_r;
            if (full) begin
              res_ev_r     <= 1'b1;
              res_ev_key_r <= min_key_r;
            end else begin
              fill_r       <= fill_r + FW'(1);
              res_ev_r     <= 1'b0;
              res_ev_key_r <= '0;
            end
          end
          state_r <= S_RESP;
        end
        S_RESP: begin
          if (out_load) begin
            out_tdata_r  <= {7'b0, res_ev_key_r, res_face_r, res_glyph_r};
            out_tuser_r  <= {res_ev_r, res_hit_r, res_found_r};
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/glc_checker.sv
// Port-level checker for the glyph LRU cache and its bind to the top level.
// Depends on glyph_lru_cache only through its port names.
module glc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata,
  input logic [2:0]  out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_hit_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tuser[0] && !out_tuser[2])
    else $error("hit without found or with eviction");

  a_evict_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[2] |-> out_tuser[0])
    else $error("eviction reported on a result that returns no entry");

  a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata == 48'd0 && out_tuser == 3'd0)
    else $error("result without entry carries non-zero fields");

  a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken again straight after a transfer");

endmodule

bind glyph_lru_cache glc_checker u_glc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

>>> bench/tb_glyph_lru_cache.sv
`timescale 1ns / 100ps
// Self-checking bench for glyph_lru_cache: directed and random lookups and clears over the
// stream ports, checked against a behavioural LRU cache model. Depends on glc_pkg and the RTL.
module tb_glyph_lru_cache;
  import glc_pkg::*;

  localparam int CACHE_DEPTH = 64;
  localparam int RAND_ITEMS  = 900;
  localparam int IDLE_LIMIT  = 1000;
  localparam int DRAIN_WAIT  = 80;

  typedef struct packed {
    req_type_t kind;
    key_t      code;
    glyph_t    gid;
    face_t     fsel;
    logic      load;
  } glyph_req_t;

  typedef struct packed {
    logic   found;
    logic   hit;
    glyph_t glyph;
    face_t  face;
    logic   evicted;
    key_t   ev_char;
  } glyph_resp_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic [2:0]  out_tuser;

  glyph_lru_cache #(.CACHE_ENTRIES(CACHE_DEPTH)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Model of the cache contents.
  key_t   line_key   [CACHE_DEPTH];
  glyph_t line_glyph [CACHE_DEPTH];
  face_t  line_face  [CACHE_DEPTH];
  stamp_t line_stamp [CACHE_DEPTH];
  int     lines_used = 0;
  stamp_t req_clock  = '0;

  glyph_req_t  pending_requests[$];
  glyph_resp_t predicted_replies[$];

  int requests_taken = 0;
  int replies_seen   = 0;
  int hits_seen      = 0;
  int fills_seen     = 0;
  int evictions_seen = 0;
  int clears_seen    = 0;
  int misses_dropped = 0;
  int mismatches     = 0;
  int total_requests = 0;

  function automatic glyph_resp_t lookup_glyph(glyph_req_t r);
    glyph_resp_t res;
    stamp_t      now;
    int          slot;
    res = '0;
    if (r.kind == REQ_CLEAR) begin
      lines_used = 0;
      clears_seen++;
      return res;
    end
    now = req_clock;
    req_clock = req_clock + 1'b1;
    for (int i = 0; i < lines_used; i++) begin
      if (line_key[i] == r.code) begin
        line_stamp[i] = now;
        res.found = 1'b1;
        res.hit   = 1'b1;
        res.glyph = line_glyph[i];
        res.face  = line_face[i];
        hits_seen++;
        return res;
      end
    end
    if (!r.load) begin
      misses_dropped++;
      return res;
    end
    if (lines_used < CACHE_DEPTH) begin
      slot = lines_used;
      lines_used++;
    end else begin
      // The oldest stamp goes; on equal stamps the lowest index wins.
      slot = 0;
      for (int i = 1; i < CACHE_DEPTH; i++)
        if (line_stamp[i] < line_stamp[slot]) slot = i;
      res.evicted = 1'b1;
      res.ev_char = line_key[slot];
      evictions_seen++;
    end
    line_key[slot]   = r.code;
    line_glyph[slot] = r.gid;
    line_face[slot]  = r.fsel;
    line_stamp[slot] = now;
    res.found = 1'b1;
    res.glyph = r.gid;
    res.face  = r.fsel;
    fills_seen++;
    return res;
  endfunction

  function automatic void queue_request(req_type_t kind, key_t code, glyph_t gid,
                                        face_t fsel, logic load);
    glyph_req_t r;
    r.kind = kind;
    r.code = code;
    r.gid  = gid;
    r.fsel = fsel;
    r.load = load;
    pending_requests.push_back(r);
  endfunction

  // Driver: bursts of back-to-back transfers separated by random gaps.
  int burst_left = 1;
  int gap_left   = 0;

  always @(posedge clk) begin : drive_requests
    glyph_req_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (gap_left != 0) begin
        gap_left  <= gap_left - 1;
        in_tvalid <= 1'b0;
      end else if (pending_requests.size() != 0) begin
        nxt = pending_requests.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= {6'b0, nxt.load, nxt.fsel, nxt.gid, nxt.code};
        in_tuser  <= nxt.kind;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: runs of ready and stall of random length, some ready runs long.
  int ready_left = 0;

  always @(posedge clk) begin : drive_ready
    int mode;
    if (!rst_n) begin
      out_tready <= 1'b0;
      ready_left <= 0;
    end else if (ready_left == 0) begin
      mode = $urandom_range(0, 3);
      if (mode == 0) begin
        out_tready <= 1'b0;
        ready_left <= $urandom_range(1, 24);
      end else begin
        out_tready <= 1'b1;
        ready_left <= $urandom_range(1, (mode == 3) ? 300 : 30);
      end
    end else begin
      ready_left <= ready_left - 1;
    end
  end

  // Monitor: checks each result transfer, then predicts from each request transfer.
  always @(posedge clk) begin : check_replies
    glyph_resp_t got;
    glyph_resp_t want;
    glyph_req_t  taken;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got.found   = out_tuser[0];
        got.hit     = out_tuser[1];
        got.evicted = out_tuser[2];
        got.glyph   = out_tdata[15:0];
        got.face    = out_tdata[19:16];
        got.ev_char = out_tdata[40:20];
        replies_seen++;
        if (predicted_replies.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result with no request outstanding: found=%0b hit=%0b glyph=%h",
                     $realtime, got.found, got.hit, got.glyph);
        end else begin
          want = predicted_replies.pop_front();
          if (got != want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: result %0d wrong", $realtime, replies_seen);
              $display("  expected found=%0b hit=%0b glyph=%h face=%h evicted=%0b key=%h",
                       want.found, want.hit, want.glyph, want.face, want.evicted,
                       want.ev_char);
              $display("  actual   found=%0b hit=%0b glyph=%h face=%h evicted=%0b key=%h",
                       got.found, got.hit, got.glyph, got.face, got.evicted, got.ev_char);
            end
          end
        end
      end
      if (in_tvalid && in_tready) begin
        taken.code = in_tdata[20:0];
        taken.gid  = in_tdata[36:21];
        taken.fsel = in_tdata[40:37];
        taken.load = in_tdata[41];
        taken.kind = req_type_t'(in_tuser);
        predicted_replies.push_back(lookup_glyph(taken));
        requests_taken++;
      end
    end
  end

  // Watchdog on cycles without any transfer.
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("Timeout: no transfer for %0d cycles", IDLE_LIMIT);
        $display("Some tests failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin : stimulus
    key_t key_pool[256];
    int   made;
    int   psize;
    int   hot;
    int   phase_len;
    int   pick;
    key_t code;

    // Directed: extremes of the fields, failed and successful misses, hits, clears.
    queue_request(REQ_CLEAR,  21'h000000, 16'hFFFF, 4'hF, 1'b1);
    queue_request(REQ_LOOKUP, 21'h000000, 16'h1234, 4'h3, 1'b0);
    queue_request(REQ_LOOKUP, 21'h000000, 16'hFFFF, 4'hF, 1'b1);
    queue_request(REQ_LOOKUP, 21'h000000, 16'h0000, 4'h0, 1'b0);
    queue_request(REQ_LOOKUP, 21'h10FFFF, 16'h0000, 4'h0, 1'b1);
    // A hit ignores the face and glyph of the request.
    queue_request(REQ_LOOKUP, 21'h10FFFF, 16'hBEEF, 4'h5, 1'b1);
    queue_request(REQ_LOOKUP, 21'h0AAAAA, 16'hAAAA, 4'hA, 1'b1);
    queue_request(REQ_LOOKUP, 21'h0F5555, 16'h5555, 4'h5, 1'b1);
    queue_request(REQ_LOOKUP, 21'h012345, 16'h0F0F, 4'h9, 1'b0);
    queue_request(REQ_LOOKUP, 21'h012345, 16'h0F0F, 4'h9, 1'b1);
    queue_request(REQ_LOOKUP, 21'h0AAAAA, 16'h0000, 4'h0, 1'b0);
    queue_request(REQ_LOOKUP, 21'h000000, 16'h0001, 4'h1, 1'b1);
    queue_request(REQ_CLEAR,  21'h1FFFFF, 16'h0000, 4'h0, 1'b0);
    queue_request(REQ_LOOKUP, 21'h10FFFF, 16'h4321, 4'h2, 1'b0);
    queue_request(REQ_LOOKUP, 21'h000000, 16'h7FFF, 4'h8, 1'b1);
    queue_request(REQ_LOOKUP, 21'h000000, 16'h0000, 4'h0, 1'b1);
    queue_request(REQ_LOOKUP, 21'h100000, 16'h8000, 4'h7, 1'b1);
    queue_request(REQ_CLEAR,  21'h000000, 16'h0000, 4'h0, 1'b0);
    queue_request(REQ_CLEAR,  21'h000000, 16'h0000, 4'h0, 1'b0);
    queue_request(REQ_LOOKUP, 21'h100000, 16'h0000, 4'h0, 1'b0);

    // Random phases over key pools of different sizes; pools larger than the cache
    // force evictions, and a hot subset keeps some entries recently used.
    made = 0;
    while (made < RAND_ITEMS) begin
      case ($urandom_range(0, 4))
        0:       psize = 8;
        1:       psize = 48;
        2:       psize = 70;
        3:       psize = 100;
        default: psize = 200;
      endcase
      hot = (psize / 4 > 0) ? psize / 4 : 1;
      for (int j = 0; j < psize; j++)
        key_pool[j] = $urandom_range(0, 1) ? key_t'($urandom_range(0, 1114111))
                                            : key_t'($urandom_range(0, 255));
      if ($urandom_range(0, 2) == 0) begin
        queue_request(REQ_CLEAR, key_t'($urandom_range(0, 1114111)),
                      glyph_t'($urandom_range(0, 65535)), face_t'($urandom_range(0, 15)),
                      1'($urandom_range(0, 1)));
        made++;
      end
      phase_len = $urandom_range(60, 200);
      for (int k = 0; k < phase_len && made < RAND_ITEMS; k++) begin
        pick = $urandom_range(0, 249);
        if (pick == 0) begin
          queue_request(REQ_CLEAR, key_t'($urandom_range(0, 1114111)),
                        glyph_t'($urandom_range(0, 65535)), face_t'($urandom_range(0, 15)),
                        1'($urandom_range(0, 1)));
        end else if (pick < 8) begin
          queue_request(REQ_LOOKUP, key_t'($urandom_range(0, 1114111)),
                        glyph_t'($urandom_range(0, 65535)), face_t'($urandom_range(0, 15)),
                        1'($urandom_range(0, 1)));
        end else begin
          code = $urandom_range(0, 1) ? key_pool[$urandom_range(0, hot - 1)]
                                      : key_pool[$urandom_range(0, psize - 1)];
          queue_request(REQ_LOOKUP, code, glyph_t'($urandom_range(0, 65535)),
                        face_t'($urandom_range(0, 15)), 1'($urandom_range(0, 9) != 0));
        end
        made++;
      end
    end
    total_requests = pending_requests.size();

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (requests_taken < total_requests || predicted_replies.size() != 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Ran %0d requests: %0d hits, %0d fills, %0d evictions, %0d clears,",
             requests_taken, hits_seen, fills_seen, evictions_seen, clears_seen);
    $display("%0d misses without load; %0d results checked, %0d mismatches.",
             misses_dropped, replies_seen, mismatches);
    if (mismatches == 0 && predicted_replies.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/glc_pkg.sv
rtl/glc_ram.sv
rtl/glc_cmp.sv
rtl/glyph_lru_cache.sv
rtl/glc_checker.sv
bench/tb_glyph_lru_cache.sv
